// ===== rtl/core/mwfd_pkg.sv =====
// Package for the magic word frame deframer: types, register codes and reset values.
`timescale 1ns / 1ps

package mwfd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] HEADER_RESET = 32'h18AB_C427;
    localparam logic [WORD_W-1:0] FOOTER_RESET = 32'h9ABE_8873;
    localparam logic [WORD_W-1:0] MAXPAY_RESET = 32'd65535;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXPAY = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SENDER  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FOOTER  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NAK  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] header_word;
        logic [WORD_W-1:0] footer_word;
        logic [WORD_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] src_id;
        logic [WORD_W-1:0] payload_length;
    } result_t;

endpackage

// ===== rtl/core/mwfd_cfg.sv =====
// Configuration register file of the frame deframer.
`timescale 1ns / 1ps

module mwfd_cfg
    import mwfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write the addressed register; drop writes to unused indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_word <= HEADER_RESET;
            cfg_reg.footer_word <= FOOTER_RESET;
            cfg_reg.max_payload <= MAXPAY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEADER: cfg_reg.header_word <= cfg_data;
                REG_FOOTER: cfg_reg.footer_word <= cfg_data;
                REG_MAXPAY: cfg_reg.max_payload <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/mwfd_core.sv =====
// Frame parser: phase state, counters and the result of one received byte.
`timescale 1ns / 1ps

module mwfd_core
    import mwfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [BYTE_W-1:0] in_byte,
    input  cfg_t              cfg,
    output result_t           result
);

    phase_t            phase_reg,  phase_next;
    logic [WORD_W-1:0] window_reg, window_next;
    logic [WORD_W-1:0] count_reg,  count_next;
    logic [BYTE_W-1:0] sender_reg, sender_next;
    logic [WORD_W-1:0] length_reg, length_next;
    logic [WORD_W-1:0] byte_shifted;
    logic [WORD_W-1:0] count_inc;

    // Place the byte at its little-endian lane within a word
    assign byte_shifted = {{(WORD_W-BYTE_W){1'b0}}, in_byte} << {count_reg[1:0], 3'b000};
    assign count_inc    = count_reg + 32'd1;

    // Next state and result
    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        sender_next = sender_reg;
        length_next = length_reg;
        result.valid          = 1'b0;
        result.kind           = KIND_DATA;
        result.data_byte      = '0;
        case (phase_reg)
            PH_SENDER: begin
                sender_next = in_byte;
                length_next = '0;
                count_next  = '0;
                phase_next  = PH_LENGTH;
            end
            PH_LENGTH: begin
                length_next = length_reg | byte_shifted;
                count_next  = count_inc;
                if (count_reg[1:0] == 2'd3) begin
                    if (length_next == '0 || length_next > cfg.max_payload) begin
                        phase_next   = PH_HUNT;
                        window_next  = '0;
                        count_next   = '0;
                        result.valid = 1'b1;
                        result.kind  = KIND_NAK;
                    end else begin
                        count_next = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                count_next       = count_inc;
                result.valid     = 1'b1;
                result.kind      = KIND_DATA;
                result.data_byte = in_byte;
                if (count_inc >= length_reg) begin
                    phase_next  = PH_FOOTER;
                    count_next  = '0;
                    window_next = '0;
                end
            end
            PH_FOOTER: begin
                window_next = window_reg | byte_shifted;
                count_next  = count_inc;
                if (count_reg[1:0] == 2'd3) begin
                    result.valid = 1'b1;
                    result.kind  = (window_next == cfg.footer_word) ? KIND_ACK : KIND_NAK;
                    phase_next   = PH_HUNT;
                    window_next  = '0;
                    count_next   = '0;
                end
            end
            default: begin
                // Hunt: slide the window, oldest byte least significant
                phase_next  = PH_HUNT;
                window_next = {in_byte, window_reg[WORD_W-1:BYTE_W]};
                if (count_reg < 32'd4) begin
                    count_next = count_inc;
                end
                if (count_next >= 32'd4 && window_next == cfg.header_word) begin
                    phase_next = PH_SENDER;
                    count_next = '0;
                end
            end
        endcase
        result.src_id         = sender_next;
        result.payload_length = length_next;
    end

    // Advance state once per taken item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            count_reg  <= '0;
            sender_reg <= '0;
            length_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            sender_reg <= sender_next;
            length_reg <= length_next;
        end
    end

endmodule

// ===== rtl/core/magic_word_frame_deframer.sv =====
// Magic word frame deframer top level: input register, parser, result register.
// A byte is held in the input register, and its parsed result is loaded into the result register.
// Throughput: one byte per cycle unless stalled; the parser advances as each held byte moves on.
// The input side stalls only while the result register holds an item not yet taken.
// Reset (aresetn low, synchronous): header hunt, cleared window and counters, registers
// at their defaults, both pipeline registers empty.
`timescale 1ns / 1ps

module magic_word_frame_deframer
    import mwfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [BYTE_W-1:0]    m_data_byte,
    output logic [BYTE_W-1:0]    m_src_id,
    output logic [WORD_W-1:0]    m_payload_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    cfg_t              cfg;
    result_t           result;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    result_t           out_reg;
    logic              advance;

    mwfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move the held item into the parser when the result slot is free or being taken
    assign advance = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg.valid <= result.valid;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
        if (advance && result.valid) begin
            out_reg.kind           <= result.kind;
            out_reg.data_byte      <= result.data_byte;
            out_reg.src_id         <= result.src_id;
            out_reg.payload_length <= result.payload_length;
        end
    end

    assign m_valid          = out_reg.valid;
    assign m_kind           = out_reg.kind;
    assign m_data_byte      = out_reg.data_byte;
    assign m_src_id         = out_reg.src_id;
    assign m_payload_length = out_reg.payload_length;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the magic word frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb;

    import mwfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 100_000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned PHASE_BYTES   = 110;
    localparam int unsigned IDLE_SWAP_AT  = 250;
    localparam int unsigned IDLE_OFF_AT   = 500;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  sender;
        logic [31:0] length;
    } deframe_result_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           value;
        logic                  typed;
        deframe_result_t       want;
    } stim_row_t;

    localparam deframe_result_t NO_RES = '0;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_kind;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [BYTE_W-1:0]    m_src_id;
    logic [WORD_W-1:0]    m_payload_length;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
    logic [WORD_W-1:0]    cfg_data = '0;

    // Predictor copy of the registers and the parser state
    logic [31:0] hdr_word = HEADER_RESET;
    logic [31:0] ftr_word = FOOTER_RESET;
    logic [31:0] max_len = MAXPAY_RESET;
    logic [31:0] hunt_window = '0;
    phase_t      frame_phase = PH_HUNT;
    logic [31:0] field_cnt = '0;
    logic [7:0]  cur_sender = '0;
    logic [31:0] cur_length = '0;

    deframe_result_t pending_results[$];
    deframe_result_t got_res;
    stim_row_t       directed_plan[$];
    logic [7:0]      link_q[$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 57;
    int unsigned hold_left = 0;
    logic        hold_request = 1'b0;

    magic_word_frame_deframer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_src_id         (m_src_id),
        .m_payload_length (m_payload_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Drive result-side ready: a long hold-off on request, else random stalls
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d data %02h sender %02h length %08h",
                             m_kind, m_data_byte, m_src_id, m_payload_length);
            end else begin
                got_res = pending_results.pop_front();
                if (m_kind !== got_res.kind || m_data_byte !== got_res.data ||
                    m_src_id !== got_res.sender || m_payload_length !== got_res.length) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"mismatch (expected/actual): kind %0d/%0d data %02h/%02h ",
                                  "sender %02h/%02h length %08h/%08h"},
                                 got_res.kind, m_kind, got_res.data, m_data_byte,
                                 got_res.sender, m_src_id, got_res.length, m_payload_length);
                end
            end
        end
    end

    // Return the parser to header hunt with a cleared window
    function automatic void restart_hunt();
        frame_phase = PH_HUNT;
        hunt_window = '0;
        field_cnt = '0;
    endfunction

    // Advance the parser by one byte; report the result it causes, if any
    task automatic deframe_byte(input logic [7:0] b, output logic got,
                                output deframe_result_t r);
        logic good;
        got = 1'b0;
        r = NO_RES;
        case (frame_phase)
            PH_SENDER: begin
                cur_sender = b;
                cur_length = '0;
                field_cnt = '0;
                frame_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                cur_length = cur_length | ({24'h0, b} << (8 * field_cnt[1:0]));
                field_cnt = field_cnt + 1;
                if (field_cnt >= 4) begin
                    if (cur_length == 0 || cur_length > max_len) begin
                        restart_hunt();
                        r.kind = KIND_NAK;
                        got = 1'b1;
                    end else begin
                        field_cnt = '0;
                        frame_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                field_cnt = field_cnt + 1;
                if (field_cnt >= cur_length) begin
                    frame_phase = PH_FOOTER;
                    field_cnt = '0;
                    hunt_window = '0;
                end
                r.kind = KIND_DATA;
                r.data = b;
                got = 1'b1;
            end
            PH_FOOTER: begin
                hunt_window = hunt_window | ({24'h0, b} << (8 * field_cnt[1:0]));
                field_cnt = field_cnt + 1;
                if (field_cnt >= 4) begin
                    good = (hunt_window == ftr_word);
                    restart_hunt();
                    r.kind = good ? KIND_ACK : KIND_NAK;
                    got = 1'b1;
                end
            end
            default: begin
                // hunt: slide the window, oldest byte lowest
                frame_phase = PH_HUNT;
                hunt_window = {b, hunt_window[31:8]};
                if (field_cnt < 4) field_cnt = field_cnt + 1;
                if (field_cnt >= 4 && hunt_window == hdr_word) begin
                    frame_phase = PH_SENDER;
                    field_cnt = '0;
                end
            end
        endcase
        r.sender = cur_sender;
        r.length = cur_length;
    endtask

    // Offer one byte, wait for it to be taken, then log what it should cause
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input deframe_result_t want);
        logic got;
        deframe_result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_byte(b, got, r);
        if (typed) pending_results.push_back(want);
        else if (got) pending_results.push_back(r);
        bytes_sent++;
        if (bytes_sent == IDLE_SWAP_AT) begin
            send_idle_pct = 57;
            recv_idle_pct = 16;
        end else if (bytes_sent == IDLE_OFF_AT) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_HEADER: hdr_word = v;
            REG_FOOTER: ftr_word = v;
            REG_MAXPAY: max_len = v;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) link_q.push_back(w[8*i +: 8]);
    endtask

    // Queue a frame (or line noise); a nonzero fixed_len gives a clean frame of that length
    task automatic queue_frame(input logic [31:0] fixed_len);
        int unsigned pick;
        int unsigned len_pick;
        int unsigned cap;
        logic [31:0] hdr;
        logic [31:0] len;
        logic [31:0] ftr;
        pick = (fixed_len != 0) ? 99 : $urandom_range(99);
        len_pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) link_q.push_back(8'($urandom_range(255)));
        end else begin
            hdr = hdr_word;
            if (pick < 15) hdr = hdr ^ (32'h1 << $urandom_range(31));
            if (fixed_len != 0) begin
                len = fixed_len;
            end else if (len_pick < 10) begin
                len = '0;
            end else if ((len_pick < 22 || max_len == 0) && max_len != 32'hFFFF_FFFF) begin
                len = $urandom_range(1) ? 32'hFFFF_FFFF : max_len + 1 + ($urandom % ~max_len);
            end else begin
                cap = (len_pick >= 96) ? 48 : 12;
                if (max_len < cap) cap = max_len;
                len = $urandom_range(1, cap);
            end
            queue_word(hdr);
            link_q.push_back(8'($urandom_range(255)));
            queue_word(len);
            if (len != 0 && len <= max_len) begin
                repeat (len) link_q.push_back(8'($urandom_range(255)));
                ftr = ftr_word;
                if (fixed_len == 0 && $urandom_range(99) < 20)
                    ftr = ftr ^ (32'h1 << $urandom_range(31));
                queue_word(ftr);
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] v, input logic typed, input deframe_result_t want);
        stim_row_t row;
        row.op = ROW_BYTE;
        row.idx = REG_HEADER;
        row.value = {24'h0, v};
        row.typed = typed;
        row.want = want;
        directed_plan.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        stim_row_t row;
        row.op = ROW_CFG;
        row.idx = idx;
        row.value = v;
        row.typed = 1'b0;
        row.want = NO_RES;
        directed_plan.push_back(row);
    endtask

    function automatic deframe_result_t res(input kind_t k, input logic [7:0] d,
                                            input logic [7:0] s, input logic [31:0] l);
        deframe_result_t r;
        r.kind = k;
        r.data = d;
        r.sender = s;
        r.length = l;
        return r;
    endfunction

    initial begin
        logic [31:0] new_hdr;
        logic [31:0] new_ftr;
        logic [31:0] new_max;
        int unsigned phase_end;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: unused index write (must be ignored), good frame at reset values,
        // then a zero-length frame under the widest length limit
        add_reg(REG_UNUSED, 32'h0000_0000);
        add_byte(8'h27, 1'b0, NO_RES);      // reset header, low byte first
        add_byte(8'hC4, 1'b0, NO_RES);
        add_byte(8'hAB, 1'b0, NO_RES);
        add_byte(8'h18, 1'b0, NO_RES);
        add_byte(8'hFF, 1'b0, NO_RES);      // sender id
        add_byte(8'h02, 1'b0, NO_RES);      // length 2
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b1, res(KIND_DATA, 8'h00, 8'hFF, 32'd2));
        add_byte(8'hFF, 1'b1, res(KIND_DATA, 8'hFF, 8'hFF, 32'd2));
        add_byte(8'h73, 1'b0, NO_RES);      // reset footer
        add_byte(8'h88, 1'b0, NO_RES);
        add_byte(8'hBE, 1'b0, NO_RES);
        add_byte(8'h9A, 1'b1, res(KIND_ACK, 8'h00, 8'hFF, 32'd2));
        add_reg(REG_MAXPAY, 32'hFFFF_FFFF);
        add_byte(8'h27, 1'b0, NO_RES);
        add_byte(8'hC4, 1'b0, NO_RES);
        add_byte(8'hAB, 1'b0, NO_RES);
        add_byte(8'h18, 1'b0, NO_RES);
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b0, NO_RES);      // zero length is always rejected
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b0, NO_RES);
        add_byte(8'h00, 1'b1, res(KIND_NAK, 8'h00, 8'h00, 32'd0));

        foreach (directed_plan[i]) begin
            if (directed_plan[i].op == ROW_CFG)
                write_reg(directed_plan[i].idx, directed_plan[i].value);
            else
                send_byte(directed_plan[i].value[7:0], directed_plan[i].typed,
                          directed_plan[i].want);
        end

        // Random frames under several register settings, extremes included
        for (int cfg_step = 0; cfg_step < 6; cfg_step++) begin
            case (cfg_step)
                0: begin new_hdr = $urandom; new_ftr = $urandom; new_max = 32'd64; end
                1: begin new_hdr = 32'h0000_0000; new_ftr = 32'hFFFF_FFFF; new_max = 32'd12; end
                2: begin new_hdr = 32'hFFFF_FFFF; new_ftr = 32'h0000_0000; new_max = 32'd1; end
                3: begin new_hdr = $urandom; new_ftr = $urandom; new_max = 32'hFFFF_FFFF; end
                4: begin new_hdr = $urandom; new_ftr = $urandom; new_max = 32'd0; end
                default: begin
                    new_hdr = HEADER_RESET;
                    new_ftr = FOOTER_RESET;
                    new_max = $urandom_range(6, 20);
                end
            endcase
            write_reg(REG_HEADER, new_hdr);
            write_reg(REG_FOOTER, new_ftr);
            write_reg(REG_MAXPAY, new_max);

            // Hold off the receiver through a long payload so the input side backs up
            if (cfg_step == 0) begin
                @(posedge aclk);
                hold_request = 1'b1;
                queue_frame(32'd40);
                while (link_q.size() != 0) send_byte(link_q.pop_front(), 1'b0, NO_RES);
            end

            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                queue_frame(32'd0);
                while (link_q.size() != 0) send_byte(link_q.pop_front(), 1'b0, NO_RES);
            end
        end

        // Change the footer in the middle of a payload; the new value must apply
        queue_frame(32'd6);
        repeat (12) send_byte(link_q.pop_front(), 1'b0, NO_RES);
        write_reg(REG_FOOTER, $urandom);
        repeat (4) void'(link_q.pop_back());
        queue_word(ftr_word);
        while (link_q.size() != 0) send_byte(link_q.pop_front(), 1'b0, NO_RES);

        // Drain and settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
